// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the bitmap engine RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/abe_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap engine package
// Sizes, operation codes, word types and the byte priority encoder.
// ----------------------------------------------------------------------------
package abe_pkg;

  localparam int NUM_BITS  = 4096;
  localparam int BYTES     = (NUM_BITS + 7) / 8;
  localparam int ADDR_W    = (BYTES > 1) ? $clog2(BYTES) : 1;
  localparam int IDX_W     = 12;
  localparam int FOUND_W   = 13;
  localparam int OFS_W     = 3;
  localparam int BYTE_W    = 8;
  // wide enough for byte*8+bit and for NUM_BITS itself
  localparam int CALC_W    = (ADDR_W + 4 > FOUND_W) ? ADDR_W + 4 : FOUND_W;
  localparam logic [BYTE_W-1:0] FULL_BYTE = 8'hFF;
  localparam logic [CALC_W-1:0] NUM_BITS_C = CALC_W'(NUM_BITS);
  localparam logic [ADDR_W-1:0] LAST_BYTE  = ADDR_W'(BYTES - 1);

  typedef enum logic [1:0] {
    OP_SET   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_TEST  = 2'd2,
    OP_FIND  = 2'd3
  } op_e;

  typedef struct packed {
    logic [IDX_W-1:0] bit_index;
    op_e              func;
  } req_t;

  typedef struct packed {
    logic               out_of_range;
    logic               bit_value;
    logic [FOUND_W-1:0] found_index;
  } res_t;

  // position of the lowest zero bit; its result is used only for a byte that is not full
  function automatic logic [OFS_W-1:0] lowest_zero(input logic [BYTE_W-1:0] b);
    logic [OFS_W-1:0] pos;
    pos = '0;
    for (int j = BYTE_W - 1; j >= 0; j--) begin
      if (!b[j]) pos = OFS_W'(j);
    end
    return pos;
  endfunction

endpackage

// File: rtl/abe_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data (old data on collision).
// ----------------------------------------------------------------------------
module abe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/abe_core.sv
// ----------------------------------------------------------------------------
// Bitmap engine core
// Clear pass, read-modify-write of one byte, and byte-by-byte zero scan.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module abe_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  abe_pkg::req_t req_i,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output abe_pkg::res_t res_o
);
  import abe_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RMW,
    ST_SCAN,
    ST_WAIT
  } state_e;

  state_e             state_q, state_d;
  logic [ADDR_W-1:0]  ptr_q, ptr_d;     // clear address, rmw byte or scan byte
  logic [OFS_W-1:0]   ofs_q, ofs_d;
  op_e                op_q, op_d;
  logic               oor_q, oor_d;
  res_t               hold_q, hold_d;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [BYTE_W-1:0]  ram_wdata, ram_rdata;

  logic [CALC_W-1:0]  idx_ext, found_calc;
  logic               in_oor;
  logic [BYTE_W-1:0]  bit_mask;
  res_t               res_now;
  logic               done_now;

  abe_ram #(.WIDTH(BYTE_W), .DEPTH(BYTES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign idx_ext    = CALC_W'(req_i.bit_index);
  assign in_oor     = (idx_ext >= NUM_BITS_C);
  assign bit_mask   = BYTE_W'(1) << ofs_q;
  assign found_calc = (CALC_W'({ptr_q, lowest_zero(ram_rdata)}) >= NUM_BITS_C) ? NUM_BITS_C :
                      CALC_W'({ptr_q, lowest_zero(ram_rdata)});
  assign req_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    ofs_d     = ofs_q;
    op_d      = op_q;
    oor_d     = oor_q;
    hold_d    = hold_q;
    ram_we    = 1'b0;
    ram_waddr = ptr_q;
    ram_wdata = '0;
    ram_raddr = '0;
    res_now   = '0;
    done_now  = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        ram_we = 1'b1;
        ptr_d  = ptr_q + ADDR_W'(1);
        if (ptr_q == LAST_BYTE) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_i.func == OP_FIND) begin
          ram_raddr = '0;
        end else if (!in_oor) begin
          ram_raddr = idx_ext[ADDR_W+OFS_W-1:OFS_W];
        end
        if (req_valid_i) begin
          op_d  = req_i.func;
          oor_d = in_oor && (req_i.func != OP_FIND);
          ofs_d = req_i.bit_index[OFS_W-1:0];
          ptr_d = (req_i.func == OP_FIND || in_oor) ? '0 :
                  idx_ext[ADDR_W+OFS_W-1:OFS_W];
          state_d = (req_i.func == OP_FIND) ? ST_SCAN : ST_RMW;
        end
      end
      ST_RMW: begin
        done_now = 1'b1;
        res_now.out_of_range = oor_q;
        res_now.bit_value    = (op_q == OP_TEST) && !oor_q && |(ram_rdata & bit_mask);
        if (!oor_q && (op_q == OP_SET || op_q == OP_CLEAR)) begin
          ram_we    = 1'b1;
          ram_wdata = (op_q == OP_SET) ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask);
        end
      end
      ST_SCAN: begin
        ram_raddr = ptr_q + ADDR_W'(1);
        if (ram_rdata != FULL_BYTE) begin
          done_now = 1'b1;
          res_now.found_index = found_calc[FOUND_W-1:0];
        end else if (ptr_q == LAST_BYTE) begin
          done_now = 1'b1;
          res_now.found_index = NUM_BITS_C[FOUND_W-1:0];
        end else begin
          ptr_d = ptr_q + ADDR_W'(1);
        end
      end
      ST_WAIT: begin
        if (res_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase

    if (done_now) begin
      hold_d  = res_now;
      state_d = res_ready_i ? ST_IDLE : ST_WAIT;
    end
  end

  assign res_valid_o = done_now || (state_q == ST_WAIT);
  assign res_o       = (state_q == ST_WAIT) ? hold_q : res_now;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      ptr_q   <= '0;
      ofs_q   <= '0;
      op_q    <= OP_SET;
      oor_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      ofs_q   <= ofs_d;
      op_q    <= op_d;
      oor_q   <= oor_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
  end

  `ASSERT_IMPLY(a_no_res_in_clear, clk_i, rst_ni, state_q == ST_CLEAR, !res_valid_o, "result during clear pass")
  `ASSERT_IMPLY(a_we_only_clr_rmw, clk_i, rst_ni, ram_we, state_q == ST_CLEAR || (state_q == ST_RMW && !oor_q), "unexpected RAM write")
  `ASSERT_NEXT(a_wait_holds, clk_i, rst_ni, state_q == ST_WAIT && !res_ready_i, state_q == ST_WAIT && $stable(hold_q), "held result lost")

endmodule

// File: rtl/allocation_bitmap_engine_unit.sv
// ----------------------------------------------------------------------------
// Allocation bitmap engine: set, clear, test, find lowest zero bit
// Set/clear/test do a read-modify-write of the addressed byte; find scans the bytes in order
// up to the first byte that is not full. A new word is taken only after the last result has left the core.
// Reset: bitmap cleared by a pass over the RAM, input stalled meanwhile.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module allocation_bitmap_engine_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [1:0] func, [13:2] bit_index, [15:14] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [12:0] found_index, [13] bit_value,
                                      // [14] out_of_range, [15] zero
);
  import abe_pkg::*;

  // Input word unpacked into the request struct.
  req_t req;
  logic res_valid, res_ready;
  res_t res;

  // Output register: decouples the core from the downstream consumer, so the
  // core can finish and take the next word while a result is still waiting.
  logic out_valid_q;
  res_t out_q;

  assign req.func      = op_e'(s_axis_tdata[1:0]);
  assign req.bit_index = s_axis_tdata[IDX_W+1:2];

  abe_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // The register takes a new result when empty or being drained this cycle.
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) out_q <= res;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q.out_of_range, out_q.bit_value, out_q.found_index};

  // A finished result always lands in the output register.
  `ASSERT_NEXT(a_res_lands, clk_i, rst_ni, res_valid && res_ready, m_axis_tvalid, "result dropped")
  // The core does not take a word in the cycle after it takes one.
  `ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready, "core took two words back to back")

endmodule
